>>> sv/acp_pkg.sv
// Shared constants for the box collision push-out block.
// No dependencies.
`default_nettype none

package acp_pkg;

  localparam int COORD_BITS = 24;

  // overlap_w * 4 > overlap_h bias, as a left shift
  localparam int BIAS_SHIFT = 2;

endpackage

`default_nettype wire

>>> sv/acp_if.sv
// Valid/ready channel interfaces for box pairs and push results.
// Depends on acp_pkg for the default coordinate width.
`default_nettype none

interface acp_box_if #(
  parameter int COORD_BITS = acp_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] our_x;
  logic signed [COORD_BITS-1:0] our_y;
  logic        [COORD_BITS-2:0] our_w;
  logic        [COORD_BITS-2:0] our_h;
  logic signed [COORD_BITS-1:0] move_x;
  logic signed [COORD_BITS-1:0] move_y;
  logic signed [COORD_BITS-1:0] other_x;
  logic signed [COORD_BITS-1:0] other_y;
  logic        [COORD_BITS-2:0] other_w;
  logic        [COORD_BITS-2:0] other_h;

  modport source (
    output valid, our_x, our_y, our_w, our_h, move_x, move_y,
           other_x, other_y, other_w, other_h,
    input  ready
  );
  modport sink (
    input  valid, our_x, our_y, our_w, our_h, move_x, move_y,
           other_x, other_y, other_w, other_h,
    output ready
  );
endinterface

interface acp_push_if #(
  parameter int COORD_BITS = acp_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] push_x;
  logic signed [COORD_BITS-1:0] push_y;
  logic                         overlapped;

  modport source (output valid, push_x, push_y, overlapped, input ready);
  modport sink   (input  valid, push_x, push_y, overlapped, output ready);
endinterface

`default_nettype wire

>>> sv/aabb_collision_pushout.sv
// Box collision push-out: overlap test, back-out along reversed motion, final push.
// Depends on acp_pkg and the channel interfaces in acp_if.sv.
//
//   channel | dir | payload
//   boxes   | in  | our box, motion, other box
//   push    | out | push_x, push_y, overlapped
//
// Eight register stages; one request per cycle unless the push channel stalls.
// Each stage holds while the next is full and stalled; bubbles close up.
// rst clears the stage valid bits only. The last stage is the output register.
`default_nettype none

module aabb_collision_pushout #(
  parameter int COORD_BITS = acp_pkg::COORD_BITS
) (
  input  wire            clk,
  input  wire            rst,
  acp_box_if.sink        boxes,
  acp_push_if.source     push
);

  localparam int CB  = COORD_BITS;
  localparam int EB  = COORD_BITS - 1;
  localparam int BS  = acp_pkg::BIAS_SHIFT;
  localparam int NST = 8;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || push.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign boxes.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= boxes.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: edges
  logic signed [CB-1:0] s1_ux, s1_uy, s1_mx, s1_my, s1_ox, s1_oy, s1_l, s1_t;
  logic        [EB-1:0] s1_uw, s1_uh;
  logic signed [CB:0]   s1_ra, s1_rb, s1_da, s1_db;
  logic signed [CB:0]   c1_ra, c1_rb, c1_da, c1_db;

  assign c1_ra = $signed({boxes.our_x[CB-1], boxes.our_x}) + $signed({2'b00, boxes.our_w});
  assign c1_rb = $signed({boxes.other_x[CB-1], boxes.other_x})
               + $signed({2'b00, boxes.other_w});
  assign c1_da = $signed({boxes.our_y[CB-1], boxes.our_y}) + $signed({2'b00, boxes.our_h});
  assign c1_db = $signed({boxes.other_y[CB-1], boxes.other_y})
               + $signed({2'b00, boxes.other_h});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_ux <= boxes.our_x;
      s1_uy <= boxes.our_y;
      s1_uw <= boxes.our_w;
      s1_uh <= boxes.our_h;
      s1_mx <= boxes.move_x;
      s1_my <= boxes.move_y;
      s1_ox <= boxes.other_x;
      s1_oy <= boxes.other_y;
      s1_l  <= (boxes.our_x > boxes.other_x) ? boxes.our_x : boxes.other_x;
      s1_t  <= (boxes.our_y > boxes.other_y) ? boxes.our_y : boxes.other_y;
      s1_ra <= c1_ra;
      s1_rb <= c1_rb;
      s1_da <= c1_da;
      s1_db <= c1_db;
    end
  end

  // stage 2: first overlap, motion magnitude
  logic signed [CB+1:0] c2_ovw, c2_ovh;
  logic signed [CB:0]   c2_r, c2_d;
  logic signed [CB-1:0] s2_ux, s2_uy, s2_ox, s2_oy;
  logic        [EB-1:0] s2_uw, s2_uh, s2_ovw, s2_ovh;
  logic        [CB-1:0] s2_ax, s2_ay;
  logic                 s2_mxn, s2_myn, s2_hit;
  logic signed [CB:0]   s2_rb, s2_db;

  assign c2_r   = (s1_ra < s1_rb) ? s1_ra : s1_rb;
  assign c2_d   = (s1_da < s1_db) ? s1_da : s1_db;
  assign c2_ovw = $signed({c2_r[CB], c2_r}) - $signed({{2{s1_l[CB-1]}}, s1_l});
  assign c2_ovh = $signed({c2_d[CB], c2_d}) - $signed({{2{s1_t[CB-1]}}, s1_t});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_ux  <= s1_ux;
      s2_uy  <= s1_uy;
      s2_uw  <= s1_uw;
      s2_uh  <= s1_uh;
      s2_ox  <= s1_ox;
      s2_oy  <= s1_oy;
      s2_rb  <= s1_rb;
      s2_db  <= s1_db;
      s2_ovw <= c2_ovw[EB-1:0];
      s2_ovh <= c2_ovh[EB-1:0];
      s2_hit <= (c2_ovw > 0) && (c2_ovh > 0);
      s2_mxn <= s1_mx[CB-1];
      s2_myn <= s1_my[CB-1];
      s2_ax  <= s1_mx[CB-1] ? (~s1_mx + 1'b1) : s1_mx;
      s2_ay  <= s1_my[CB-1] ? (~s1_my + 1'b1) : s1_my;
    end
  end

  // stage 3: back-out step
  logic        [EB-1:0] c3_sx, c3_sy;
  logic signed [CB-1:0] s3_px, s3_py, s3_ux, s3_uy, s3_ox, s3_oy;
  logic        [EB-1:0] s3_uw, s3_uh;
  logic signed [CB:0]   s3_rb, s3_db;
  logic                 s3_hit;

  assign c3_sx = (s2_ax < {1'b0, s2_ovw}) ? s2_ax[EB-1:0] : s2_ovw;
  assign c3_sy = (s2_ay < {1'b0, s2_ovh}) ? s2_ay[EB-1:0] : s2_ovh;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_px  <= s2_mxn ? $signed({1'b0, c3_sx}) : -$signed({1'b0, c3_sx});
      s3_py  <= s2_myn ? $signed({1'b0, c3_sy}) : -$signed({1'b0, c3_sy});
      s3_ux  <= s2_ux;
      s3_uy  <= s2_uy;
      s3_uw  <= s2_uw;
      s3_uh  <= s2_uh;
      s3_ox  <= s2_ox;
      s3_oy  <= s2_oy;
      s3_rb  <= s2_rb;
      s3_db  <= s2_db;
      s3_hit <= s2_hit;
    end
  end

  // stage 4: moved box position
  logic signed [CB:0]   s4_nx, s4_ny, s4_rb, s4_db;
  logic signed [CB-1:0] s4_px, s4_py, s4_ox, s4_oy;
  logic        [EB-1:0] s4_uw, s4_uh;
  logic                 s4_hit;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_nx  <= $signed({s3_ux[CB-1], s3_ux}) + $signed({s3_px[CB-1], s3_px});
      s4_ny  <= $signed({s3_uy[CB-1], s3_uy}) + $signed({s3_py[CB-1], s3_py});
      s4_px  <= s3_px;
      s4_py  <= s3_py;
      s4_ox  <= s3_ox;
      s4_oy  <= s3_oy;
      s4_uw  <= s3_uw;
      s4_uh  <= s3_uh;
      s4_rb  <= s3_rb;
      s4_db  <= s3_db;
      s4_hit <= s3_hit;
    end
  end

  // stage 5: edges of the moved box
  logic signed [CB:0]   c5_oxe, c5_oye;
  logic signed [CB:0]   s5_l, s5_t, s5_nx, s5_ny, s5_ox, s5_oy, s5_rb, s5_db;
  logic signed [CB+1:0] s5_ra, s5_da;
  logic signed [CB-1:0] s5_px, s5_py;
  logic        [EB-1:0] s5_uw;
  logic                 s5_hit;

  assign c5_oxe = $signed({s4_ox[CB-1], s4_ox});
  assign c5_oye = $signed({s4_oy[CB-1], s4_oy});

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_l   <= (s4_nx > c5_oxe) ? s4_nx : c5_oxe;
      s5_t   <= (s4_ny > c5_oye) ? s4_ny : c5_oye;
      s5_ra  <= $signed({s4_nx[CB], s4_nx}) + $signed({3'b000, s4_uw});
      s5_da  <= $signed({s4_ny[CB], s4_ny}) + $signed({3'b000, s4_uh});
      s5_nx  <= s4_nx;
      s5_ny  <= s4_ny;
      s5_ox  <= c5_oxe;
      s5_oy  <= c5_oye;
      s5_rb  <= s4_rb;
      s5_db  <= s4_db;
      s5_px  <= s4_px;
      s5_py  <= s4_py;
      s5_uw  <= s4_uw;
      s5_hit <= s4_hit;
    end
  end

  // stage 6: second overlap
  logic signed [CB+1:0] c6_r, c6_d, c6_rbe, c6_dbe;
  logic signed [CB+2:0] c6_ovw, c6_ovh;
  logic        [EB-1:0] s6_ovw, s6_ovh, s6_uw;
  logic signed [CB-1:0] s6_px, s6_py;
  logic                 s6_done, s6_xlt, s6_ylt, s6_hit;

  assign c6_rbe = $signed({s5_rb[CB], s5_rb});
  assign c6_dbe = $signed({s5_db[CB], s5_db});
  assign c6_r   = (s5_ra < c6_rbe) ? s5_ra : c6_rbe;
  assign c6_d   = (s5_da < c6_dbe) ? s5_da : c6_dbe;
  assign c6_ovw = $signed({c6_r[CB+1], c6_r}) - $signed({{2{s5_l[CB]}}, s5_l});
  assign c6_ovh = $signed({c6_d[CB+1], c6_d}) - $signed({{2{s5_t[CB]}}, s5_t});

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_ovw  <= c6_ovw[EB-1:0];
      s6_ovh  <= c6_ovh[EB-1:0];
      s6_done <= !((c6_ovw > 0) && (c6_ovh > 0));
      s6_xlt  <= s5_nx < s5_ox;
      s6_ylt  <= s5_ny < s5_oy;
      s6_uw   <= s5_uw;
      s6_px   <= s5_px;
      s6_py   <= s5_py;
      s6_hit  <= s5_hit;
    end
  end

  // stage 7: final push
  logic                 c7_vert;
  logic signed [CB:0]   c7_pxe, c7_pye, c7_dw, c7_dh, c7_px, c7_py;
  logic signed [CB:0]   s7_px, s7_py;
  logic                 s7_hit;

  assign c7_vert = (s6_ovw == s6_uw)
                || ({{BS{1'b0}}, s6_ovh} < {s6_ovw, {BS{1'b0}}});
  assign c7_pxe  = $signed({s6_px[CB-1], s6_px});
  assign c7_pye  = $signed({s6_py[CB-1], s6_py});
  assign c7_dw   = $signed({2'b00, s6_ovw});
  assign c7_dh   = $signed({2'b00, s6_ovh});

  always_comb begin
    c7_px = c7_pxe;
    c7_py = c7_pye;
    if (!s6_done) begin
      if (c7_vert) begin
        c7_py = s6_ylt ? (c7_pye - c7_dh) : (c7_pye + c7_dh);
      end else begin
        c7_px = s6_xlt ? (c7_pxe - c7_dw) : (c7_pxe + c7_dw);
      end
    end
    if (!s6_hit) begin
      c7_px = '0;
      c7_py = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_px  <= c7_px;
      s7_py  <= c7_py;
      s7_hit <= s6_hit;
    end
  end

  // stage 8: saturate into the output register
  logic signed [CB-1:0] c8_px, c8_py;
  logic signed [CB-1:0] o_px, o_py;
  logic                 o_hit;

  always_comb begin
    c8_px = s7_px[CB-1:0];
    c8_py = s7_py[CB-1:0];
    if (s7_px[CB] != s7_px[CB-1]) begin
      c8_px = s7_px[CB] ? $signed({1'b1, {EB{1'b0}}}) : $signed({1'b0, {EB{1'b1}}});
    end
    if (s7_py[CB] != s7_py[CB-1]) begin
      c8_py = s7_py[CB] ? $signed({1'b1, {EB{1'b0}}}) : $signed({1'b0, {EB{1'b1}}});
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      o_px  <= c8_px;
      o_py  <= c8_py;
      o_hit <= s7_hit;
    end
  end

  assign push.valid      = v[NST-1];
  assign push.push_x     = o_px;
  assign push.push_y     = o_py;
  assign push.overlapped = o_hit;

endmodule

`default_nettype wire

>>> test/acp_push_checker.sv
// Checker for the box collision push-out block: predicts the push for every accepted
// request and compares it with the result channel. Depends on acp_pkg and acp_if.sv.
module acp_push_checker (
  input  logic clk,
  input  logic rst,
  acp_box_if   boxes,
  acp_push_if  push,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   hits
);

  localparam longint CMAX = (longint'(1) <<< (acp_pkg::COORD_BITS - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef struct packed {
    logic signed [acp_pkg::COORD_BITS-1:0] push_x;
    logic signed [acp_pkg::COORD_BITS-1:0] push_y;
    logic                                  overlapped;
  } push_t;

  typedef struct {
    longint x, y, w, h;
  } rect_t;

  push_t  push_expect_q[$];
  int     n_fail    = 0;
  int     n_checked = 0;
  int     n_hits    = 0;
  rect_t  us, them;
  push_t  want, got;

  function automatic bit rect_overlap(input rect_t a, input rect_t b, output rect_t o);
    longint l, r, t, d;
    l = (a.x > b.x) ? a.x : b.x;
    r = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
    t = (a.y > b.y) ? a.y : b.y;
    d = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
    o = '{0, 0, 0, 0};
    if (l < r && t < d) begin
      o = '{l, t, r - l, d - t};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic signed [acp_pkg::COORD_BITS-1:0] clamp_coord(input longint v);
    longint c;
    c = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return c[acp_pkg::COORD_BITS-1:0];
  endfunction

  function automatic push_t resolve_push(input rect_t mover, input rect_t wall,
                                         input longint mx, input longint my);
    rect_t  ov;
    longint px, py, sx, sy;
    bit     hit, clear;
    push_t  res;
    px    = 0;
    py    = 0;
    clear = 1'b0;
    hit   = rect_overlap(mover, wall, ov);
    if (hit) begin
      // back out against the motion first
      if (mx != 0 || my != 0) begin
        sx = (mx < 0) ? -mx : mx;
        sy = (my < 0) ? -my : my;
        if (ov.w < sx) sx = ov.w;
        if (ov.h < sy) sy = ov.h;
        px = (mx > 0) ? -sx : sx;
        py = (my > 0) ? -sy : sy;
        mover.x += px;
        mover.y += py;
        clear = !rect_overlap(mover, wall, ov);
      end
      if (!clear) begin
        if (ov.w == mover.w || (ov.w <<< acp_pkg::BIAS_SHIFT) > ov.h) begin
          if (mover.y < wall.y) py -= ov.h; else py += ov.h;
        end else begin
          if (mover.x < wall.x) px -= ov.w; else px += ov.w;
        end
      end
    end
    res.push_x     = clamp_coord(px);
    res.push_y     = clamp_coord(py);
    res.overlapped = hit;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (boxes.valid && boxes.ready) begin
        us   = '{boxes.our_x, boxes.our_y, boxes.our_w, boxes.our_h};
        them = '{boxes.other_x, boxes.other_y, boxes.other_w, boxes.other_h};
        push_expect_q = {push_expect_q,
                         resolve_push(us, them, boxes.move_x, boxes.move_y)};
      end
      if (push.valid && push.ready) begin
        got = '{push.push_x, push.push_y, push.overlapped};
        n_checked++;
        if (got.overlapped) n_hits++;
        if (push_expect_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("ERROR: unexpected push x=%0d y=%0d overlapped=%0b",
                     got.push_x, got.push_y, got.overlapped);
        end else begin
          want = push_expect_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("ERROR: push %0d expected x=%0d y=%0d ov=%0b, got x=%0d y=%0d ov=%0b",
                       n_checked, want.push_x, want.push_y, want.overlapped,
                       got.push_x, got.push_y, got.overlapped);
          end
        end
      end
    end
    pending    <= push_expect_q.size();
    fail_count <= n_fail;
    checked    <= n_checked;
    hits       <= n_hits;
  end

endmodule

>>> test/aabb_collision_pushout_tb.sv
// Testbench top for the box collision push-out block: drives box pairs, stalls the
// push channel and gives the verdict. Depends on acp_pkg, acp_if.sv, acp_push_checker.
module aabb_collision_pushout_tb;

  localparam longint CMAX = (longint'(1) <<< (acp_pkg::COORD_BITS - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint WMAX = CMAX;

  typedef logic signed [acp_pkg::COORD_BITS-1:0] coord_t;
  typedef logic        [acp_pkg::COORD_BITS-2:0] extent_t;

  typedef struct packed {
    coord_t  our_x, our_y;
    extent_t our_w, our_h;
    coord_t  move_x, move_y;
    coord_t  other_x, other_y;
    extent_t other_w, other_h;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;
  int   sent = 0;
  int   fails, in_flight, checked, hits;

  acp_box_if  boxes ();
  acp_push_if push ();

  aabb_collision_pushout dut (
    .clk   (clk),
    .rst   (rst),
    .boxes (boxes.sink),
    .push  (push.source)
  );

  acp_push_checker chk (
    .clk        (clk),
    .rst        (rst),
    .boxes      (boxes),
    .push       (push),
    .fail_count (fails),
    .pending    (in_flight),
    .checked    (checked),
    .hits       (hits)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    push.ready <= steady || ($urandom_range(99) >= 24);
  end

  initial begin
    #(12 * 200000);
    $display("FAIL");
    $finish;
  end

  function automatic pair_t box_pair(input longint ox, input longint oy, input longint ow,
                                     input longint oh, input longint mx, input longint my,
                                     input longint tx, input longint ty, input longint tw,
                                     input longint th);
    pair_t p;
    p.our_x   = coord_t'(ox);
    p.our_y   = coord_t'(oy);
    p.our_w   = extent_t'(ow);
    p.our_h   = extent_t'(oh);
    p.move_x  = coord_t'(mx);
    p.move_y  = coord_t'(my);
    p.other_x = coord_t'(tx);
    p.other_y = coord_t'(ty);
    p.other_w = extent_t'(tw);
    p.other_h = extent_t'(th);
    return p;
  endfunction

  function automatic longint jitter(input int bits);
    return longint'($urandom_range(0, 2 << bits)) - (longint'(1) << bits);
  endfunction

  function automatic longint rim_coord();
    case ($urandom_range(2))
      0:       return CMIN + $urandom_range(255);
      1:       return CMAX - $urandom_range(255);
      default: return jitter(8);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    int     pick, s, ow, oh, tw, th;
    longint ox, oy, tx, ty, mx, my;
    pick = $urandom_range(99);
    s  = ($urandom_range(9) == 0) ? $urandom_range(22, 12) : $urandom_range(10, 2);
    ow = $urandom_range(1 << s);
    oh = $urandom_range(1 << s);
    tw = $urandom_range(1 << s);
    th = $urandom_range(1 << s);
    ox = jitter(22);
    oy = jitter(22);
    tx = ox - tw + $urandom_range(ow + tw);
    ty = oy - th + $urandom_range(oh + th);
    mx = ($urandom_range(4) == 0) ? 0 : jitter(s + 1);
    my = ($urandom_range(4) == 0) ? 0 : jitter(s + 1);
    if (pick < 12) begin
      // obstacle spans the full width of the mover
      tx = ox - $urandom_range(1 << s);
      tw = ow + int'(ox - tx) + $urandom_range(1 << s);
    end
    if (pick < 80)
      return box_pair(ox, oy, ow, oh, mx, my, tx, ty, tw, th);
    if (pick < 90)
      return box_pair(rim_coord(), rim_coord(), WMAX - $urandom_range(3),
                      WMAX - $urandom_range(3), rim_coord(), rim_coord(),
                      rim_coord(), rim_coord(), WMAX - $urandom_range(3),
                      WMAX - $urandom_range(3));
    return box_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic drive_boxes(input pair_t p);
    while (!steady && $urandom_range(99) < 24) begin
      boxes.valid <= 1'b0;
      @(posedge clk);
    end
    boxes.valid <= 1'b1;
    {boxes.our_x, boxes.our_y, boxes.our_w, boxes.our_h, boxes.move_x, boxes.move_y,
     boxes.other_x, boxes.other_y, boxes.other_w, boxes.other_h} <= p;
    do @(posedge clk); while (!boxes.ready);
    sent++;
  endtask

  task automatic drain_pushes();
    boxes.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  initial begin
    boxes.valid <= 1'b0;
    {boxes.our_x, boxes.our_y, boxes.our_w, boxes.our_h, boxes.move_x, boxes.move_y,
     boxes.other_x, boxes.other_y, boxes.other_w, boxes.other_h} <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // apart, touching, zero-width
    drive_boxes(box_pair(0, 0, 100, 100, 0, 0, 200, 200, 50, 50));
    drive_boxes(box_pair(0, 0, 100, 100, 5, 5, 100, 0, 50, 100));
    drive_boxes(box_pair(0, 0, 0, 100, 0, 0, -10, 0, 100, 100));
    drive_boxes(box_pair(0, 0, 100, 100, 40, -3, 300, -400, 10, 10));
    // no motion: vertical, horizontal both ways, full width, bias edge
    drive_boxes(box_pair(0, 0, 100, 100, 0, 0, 50, 80, 200, 200));
    drive_boxes(box_pair(0, 0, 100, 100, 0, 0, 90, -50, 200, 300));
    drive_boxes(box_pair(100, 0, 100, 100, 0, 0, -50, -50, 160, 300));
    drive_boxes(box_pair(0, 0, 10, 100, 0, 0, -20, 50, 100, 100));
    drive_boxes(box_pair(0, 0, 100, 100, 0, 0, 90, 60, 100, 100));
    drive_boxes(box_pair(0, 0, 100, 100, 0, 0, 90, 61, 100, 100));
    drive_boxes(box_pair(10, 10, 50, 50, 0, 0, 10, 10, 50, 50));
    // back-out: full clear, partial, negative, single axis
    drive_boxes(box_pair(0, 0, 100, 100, 30, 0, 80, 0, 100, 100));
    drive_boxes(box_pair(0, 0, 100, 100, 5, 5, 50, 50, 100, 100));
    drive_boxes(box_pair(50, 50, 100, 100, -5, -8, 0, 0, 100, 100));
    drive_boxes(box_pair(0, 0, 100, 100, 0, -40, 0, 80, 100, 100));
    drive_boxes(box_pair(0, 0, 100, 100, -7, 0, -90, 20, 100, 30));
    drive_boxes(box_pair(0, 0, 100, 100, 1000, 1000, 20, 20, 100, 100));
    // range extremes
    drive_boxes(box_pair(CMIN, CMIN, WMAX, WMAX, CMAX, CMIN, CMIN, CMIN, WMAX, WMAX));
    drive_boxes(box_pair(CMAX, CMAX, WMAX, WMAX, CMIN, CMAX, CMAX - 1, CMAX - 1, WMAX, WMAX));
    drive_boxes(box_pair(0, 0, WMAX, WMAX, CMIN, CMAX, 0, 0, WMAX, WMAX));
    drive_boxes(box_pair(CMIN, 0, WMAX, 4, CMAX, 0, -1, -2, WMAX, 3 * 256));
    drive_boxes(box_pair(-1, -1, 2, WMAX, CMIN, 0, CMIN, CMIN, WMAX, WMAX));
    drain_pushes();

    for (int k = 0; k < 1700; k++) begin
      steady <= (k >= 400 && k < 650);
      if (k == 900) drain_pushes();
      drive_boxes(rand_pair());
    end

    drain_pushes();
    repeat (16) @(posedge clk);
    $display("run covered %0d box pairs, %0d pushes checked, %0d with overlap",
             sent, checked, hits);
    if (fails == 0 && in_flight == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> aabb_collision_pushout.f
sv/acp_pkg.sv
sv/acp_if.sv
sv/aabb_collision_pushout.sv
test/acp_push_checker.sv
test/aabb_collision_pushout_tb.sv
